FILE: src/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types and constants for the heightmap vertex normal core.
// ----------------------------------------------------------------------------
package hvn_pkg;

	// Grid geometry.
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;
	localparam int GW_W      = 11;

	// Fixed-point formats.
	localparam int HEIGHT_W         = 24;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int FACE_SHIFT       = 21;
	localparam int VERT_SHIFT       = NORMAL_FRAC_BITS + 14;
	localparam int FACE_W           = 16;
	localparam int SUM_W            = 18;

	// Serial unit widths.
	localparam int DIV_N  = 48;
	localparam int DIV_D  = 32;
	localparam int ROOT_N = 64;
	localparam int ROOT_W = 32;

	// Vertex queue.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_GRID_WIDTH   = 2'd0,
		REG_GRID_HEIGHT  = 2'd1,
		REG_HEIGHT_SCALE = 2'd2
	} reg_idx_t;

	// Configuration register set.
	typedef struct packed {
		logic [GW_W-1:0]  grid_width;
		logic [ROW_W-1:0] grid_height;
		logic [15:0]      height_scale;
	} cfg_t;

	// One face normal in Q1.14.
	typedef struct packed {
		logic signed [FACE_W-1:0] x;
		logic signed [FACE_W-1:0] y;
		logic signed [FACE_W-1:0] z;
	} face_t;

	// One vertex job: summed face normals and position.
	typedef struct packed {
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] sz;
		logic                    last;
	} job_t;

	// Sign-extend a face component to the sum width.
	function automatic logic signed [SUM_W-1:0] ext(input logic signed [FACE_W-1:0] v);
		ext = SUM_W'(v);
	endfunction

endpackage

FILE: src/hvn_div.sv
// ----------------------------------------------------------------------------
// hvn_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hvn_div import hvn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_N-1:0] dividend,
	input  logic [DIV_D-1:0] divisor,
	output logic             done,
	output logic [DIV_N-1:0] quotient
);

	logic [DIV_N-1:0] num_q;
	logic [DIV_D-1:0] rem_q;
	logic [DIV_D-1:0] den_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_D:0]   trial;
	logic [DIV_D:0]   diff;
	logic             ge;

	// Shift in the next dividend bit and try a subtraction.
	assign trial = {rem_q, num_q[DIV_N-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(DIV_N - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath; quotient bits collect in the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
			num_q <= {num_q[DIV_N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

FILE: src/hvn_sqrt.sv
// ----------------------------------------------------------------------------
// hvn_sqrt
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module hvn_sqrt import hvn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ROOT_N-1:0] radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [ROOT_N-1:0] rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+3:0] t;
	logic [ROOT_W+3:0] trial;
	logic [ROOT_W+3:0] diff;
	logic              ge;
	logic [ROOT_W:0]   rounded;

	// One root bit per step.
	assign t     = {rem_q, rad_q[ROOT_N-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = t - trial;
	assign ge    = t >= trial;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'(ROOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[ROOT_W+1:0] : t[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			rad_q  <= {rad_q[ROOT_N-3:0], 2'b00};
		end
	end

	// Round up when the remainder exceeds the floor root.
	assign rounded = {1'b0, root_q} + {{ROOT_W{1'b0}}, (rem_q > {2'b00, root_q})};
	assign done    = done_q;
	assign root    = rounded[ROOT_W-1:0];

endmodule

FILE: src/hvn_front.sv
// ----------------------------------------------------------------------------
// hvn_front
// Accepts heights, scales them, builds face normals and issues vertex jobs.
// ----------------------------------------------------------------------------
module hvn_front import hvn_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   height,
	output job_t         job,
	output logic         job_valid,
	input  logic         job_ready
);

	typedef enum logic [8:0] {
		F_IDLE   = 9'b000000001,
		F_SCALE  = 9'b000000010,
		F_SQUARE = 9'b000000100,
		F_ROOT   = 9'b000001000,
		F_DIVX   = 9'b000010000,
		F_DIVY   = 9'b000100000,
		F_DIVZ   = 9'b001000000,
		F_PUSH   = 9'b010000000,
		F_FINISH = 9'b100000000
	} fstate_t;

	fstate_t state_q;

	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] left_q;
	logic [HEIGHT_W-1:0] cur_q;
	face_t               face_left_q;
	face_t               face_al_q;
	logic [HEIGHT_W-1:0] hl_rd_q;
	face_t               fl_rd_q;
	logic [47:0]         sqdx_q;
	logic [47:0]         sqdz_q;
	logic [ROOT_W-1:0]   len_q;
	logic signed [FACE_W-1:0] fx_q, fy_q, fz_q;
	logic [1:0]          jidx_q;
	logic                pend_q;

	logic [HEIGHT_W-1:0] hl_mem [MAX_WIDTH];
	face_t               fl_mem [MAX_WIDTH];

	// Geometry after clamping.
	logic [GW_W-1:0]  w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [15:0]      sc_eff;
	logic             row_end, frame_end;
	logic [COL_W-1:0] fc;
	logic [ROW_W-1:0] fr;
	logic             col_ge1, row_ge1, col_ge2, row_ge2;
	logic             accept;

	always_comb begin
		if (cfg.grid_width < GW_W'(2))
			w_eff = GW_W'(2);
		else if (cfg.grid_width > GW_W'(MAX_WIDTH))
			w_eff = GW_W'(MAX_WIDTH);
		else
			w_eff = cfg.grid_width;
		h_eff  = (cfg.grid_height < ROW_W'(2)) ? ROW_W'(2) : cfg.grid_height;
		sc_eff = (cfg.height_scale == '0) ? 16'd1 : cfg.height_scale;
	end

	assign row_end   = {1'b0, col_q} >= (w_eff - GW_W'(1));
	assign frame_end = row_q >= (h_eff - ROW_W'(1));
	assign fc        = col_q - COL_W'(1);
	assign fr        = row_q - ROW_W'(1);
	assign col_ge1   = col_q != '0;
	assign row_ge1   = row_q != '0;
	assign col_ge2   = col_q > COL_W'(1);
	assign row_ge2   = row_q > ROW_W'(1);
	assign in_ready  = state_q == F_IDLE;
	assign accept    = in_valid && in_ready;

	// Face differences and their squares.
	logic signed [HEIGHT_W:0] dx, dz;
	logic signed [2*HEIGHT_W+1:0] dx2, dz2;
	assign dx  = $signed({1'b0, left_q}) - $signed({1'b0, cur_q});
	assign dz  = $signed({1'b0, left_q}) - $signed({1'b0, hl_rd_q});
	assign dx2 = dx * dx;
	assign dz2 = dz * dz;

	// Divider, shared by scaling and face division, and root unit.
	logic             div_start, div_done;
	logic [DIV_N-1:0] div_num, div_q;
	logic [DIV_D-1:0] div_den;
	logic             root_start, root_done;
	logic [ROOT_N-1:0] root_rad;
	logic [ROOT_W-1:0] root_val;
	logic [48:0]       s_sum;
	logic [HEIGHT_W-1:0] mag;
	logic                neg;
	logic signed [FACE_W-1:0] comp;

	assign s_sum    = {1'b0, sqdx_q} + {1'b0, sqdz_q} + 49'd65536;
	assign root_rad = {1'b0, s_sum, 14'b0};
	assign root_start = (state_q == F_ROOT) && !pend_q;

	// Operand selection for the divider.
	always_comb begin
		mag = '0;
		neg = 1'b0;
		case (state_q)
			F_DIVX: begin
				mag = dx[HEIGHT_W] ? HEIGHT_W'(-dx) : dx[HEIGHT_W-1:0];
				neg = dx[HEIGHT_W];
			end
			F_DIVY: begin
				mag = HEIGHT_W'(256);
			end
			F_DIVZ: begin
				mag = dz[HEIGHT_W] ? HEIGHT_W'(-dz) : dz[HEIGHT_W-1:0];
				neg = dz[HEIGHT_W];
			end
			default: begin
				mag = '0;
			end
		endcase
		if (state_q == F_IDLE) begin
			div_num = {24'b0, height, 16'b0} + {33'b0, sc_eff[15:1]};
			div_den = {16'b0, sc_eff};
		end else begin
			div_num = (DIV_N'(mag) << FACE_SHIFT) + {17'b0, len_q[ROOT_W-1:1]};
			div_den = len_q;
		end
		div_start = accept ||
			((state_q == F_DIVX || state_q == F_DIVY || state_q == F_DIVZ) && !pend_q);
		comp = neg ? -$signed(div_q[FACE_W-1:0]) : $signed(div_q[FACE_W-1:0]);
	end

	hvn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	hvn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_rad),
		.done     (root_done),
		.root     (root_val)
	);

	// Vertex job selection.
	face_t f;
	logic [3:0] job_en;
	logic       use_al, use_old, use_left, job_last;
	assign f      = '{x: fx_q, y: fy_q, z: fz_q};
	assign job_en = {frame_end && row_end, frame_end, row_end, 1'b1};

	always_comb begin
		use_al   = 1'b0;
		use_old  = 1'b0;
		use_left = 1'b0;
		job.row  = fr;
		job.col  = fc;
		job_last = 1'b1;
		case (jidx_q)
			2'd0: begin
				use_al   = row_ge2 && col_ge2;
				use_old  = row_ge2;
				use_left = col_ge2;
				job_last = job_en[3:1] == '0;
			end
			2'd1: begin
				use_old  = row_ge2;
				job.col  = col_q;
				job_last = job_en[3:2] == '0;
			end
			2'd2: begin
				use_left = col_ge2;
				job.row  = row_q;
				job_last = !job_en[3];
			end
			default: begin
				job.row  = row_q;
				job.col  = col_q;
			end
		endcase
		job.sx = ext(f.x) + (use_al ? ext(face_al_q.x) : '0)
			+ (use_old ? ext(fl_rd_q.x) : '0) + (use_left ? ext(face_left_q.x) : '0);
		job.sy = ext(f.y) + (use_al ? ext(face_al_q.y) : '0)
			+ (use_old ? ext(fl_rd_q.y) : '0) + (use_left ? ext(face_left_q.y) : '0);
		job.sz = ext(f.z) + (use_al ? ext(face_al_q.z) : '0)
			+ (use_old ? ext(fl_rd_q.z) : '0) + (use_left ? ext(face_left_q.z) : '0);
		job.last = job_last;
	end

	assign job_valid = (state_q == F_PUSH) && job_en[jidx_q];

	// Sequencer and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			pend_q      <= 1'b0;
			jidx_q      <= '0;
			left_q      <= '0;
			face_left_q <= '0;
			face_al_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_SCALE;
					end
				end
				F_SCALE: begin
					if (div_done) begin
						state_q <= (col_ge1 && row_ge1) ? F_SQUARE : F_FINISH;
					end
				end
				F_SQUARE: begin
					state_q <= F_ROOT;
				end
				F_ROOT: begin
					if (root_start) pend_q <= 1'b1;
					if (root_done) begin
						pend_q  <= 1'b0;
						state_q <= F_DIVX;
					end
				end
				F_DIVX, F_DIVY, F_DIVZ: begin
					if (div_start) pend_q <= 1'b1;
					if (div_done) begin
						pend_q <= 1'b0;
						if (state_q == F_DIVX) state_q <= F_DIVY;
						else if (state_q == F_DIVY) state_q <= F_DIVZ;
						else begin
							state_q <= F_PUSH;
							jidx_q  <= '0;
						end
					end
				end
				F_PUSH: begin
					if (!job_en[jidx_q] || job_ready) begin
						jidx_q <= jidx_q + 2'd1;
						if (jidx_q == 2'd3) state_q <= F_FINISH;
					end
				end
				F_FINISH: begin
					if (col_ge1 && row_ge1) begin
						face_al_q   <= fl_rd_q;
						face_left_q <= f;
					end
					left_q <= cur_q;
					if (row_end) begin
						col_q <= '0;
						row_q <= frame_end ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == F_SCALE && div_done) cur_q <= div_q[HEIGHT_W-1:0];
		if (state_q == F_SQUARE) begin
			sqdx_q <= dx2[47:0];
			sqdz_q <= dz2[47:0];
		end
		if (state_q == F_ROOT && root_done) len_q <= root_val;
		if (div_done) begin
			if (state_q == F_DIVX) fx_q <= comp;
			if (state_q == F_DIVY) fy_q <= comp;
			if (state_q == F_DIVZ) fz_q <= comp;
		end
	end

	// Line stores: read at accept, written once the item no longer needs the old value.
	always_ff @(posedge clk) begin
		if (accept) begin
			hl_rd_q <= hl_mem[fc];
			fl_rd_q <= fl_mem[fc];
		end
		if (state_q == F_SCALE && div_done && col_ge1) hl_mem[fc] <= left_q;
		if (state_q == F_FINISH && col_ge1 && row_ge1) fl_mem[fc] <= f;
	end

endmodule

FILE: src/hvn_queue.sv
// ----------------------------------------------------------------------------
// hvn_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module hvn_queue import hvn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output job_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign push_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_data;
	end

endmodule

FILE: src/hvn_back.sv
// ----------------------------------------------------------------------------
// hvn_back
// Renormalizes summed face normals and drives the result register.
// ----------------------------------------------------------------------------
module hvn_back import hvn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  job_t                     job,
	input  logic                     job_valid,
	output logic                     job_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ROW_W-1:0]         vertex_row,
	output logic [COL_W-1:0]         vertex_col,
	output logic signed [15:0]       normal_x,
	output logic signed [15:0]       normal_y,
	output logic signed [15:0]       normal_z,
	output logic                     last
);

	typedef enum logic [6:0] {
		B_IDLE   = 7'b0000001,
		B_SQUARE = 7'b0000010,
		B_ROOT   = 7'b0000100,
		B_DIVX   = 7'b0001000,
		B_DIVY   = 7'b0010000,
		B_DIVZ   = 7'b0100000,
		B_OUT    = 7'b1000000
	} bstate_t;

	bstate_t state_q;
	job_t    job_q;
	logic [2*SUM_W-1:0] sqx_q, sqy_q, sqz_q;
	logic [ROOT_W-1:0]  len_q;
	logic signed [15:0] qx_q, qy_q, qz_q;
	logic               pend_q;
	logic               out_valid_q;
	logic               out_free;

	assign job_ready = state_q == B_IDLE;
	assign out_free  = !out_valid_q || out_ready;

	// Squared length of the sum.
	logic signed [2*SUM_W-1:0] px, py, pz;
	logic [2*SUM_W+1:0]        sq_sum;
	assign px     = job_q.sx * job_q.sx;
	assign py     = job_q.sy * job_q.sy;
	assign pz     = job_q.sz * job_q.sz;
	assign sq_sum = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};

	logic              root_start, root_done;
	logic [ROOT_N-1:0] root_rad;
	logic [ROOT_W-1:0] root_val;
	assign root_rad   = {2'b00, sq_sum[33:0], 28'b0};
	assign root_start = (state_q == B_ROOT) && !pend_q;

	hvn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_rad),
		.done     (root_done),
		.root     (root_val)
	);

	// Component selection for the divider.
	logic signed [SUM_W-1:0] s_sel;
	logic [SUM_W-1:0]        mag;
	logic                    div_start, div_done;
	logic [DIV_N-1:0]        div_num, div_q;
	logic signed [15:0]      comp;

	always_comb begin
		case (state_q)
			B_DIVX:  s_sel = job_q.sx;
			B_DIVY:  s_sel = job_q.sy;
			B_DIVZ:  s_sel = job_q.sz;
			default: s_sel = '0;
		endcase
		mag       = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : s_sel;
		div_num   = (DIV_N'(mag) << VERT_SHIFT) + {17'b0, len_q[ROOT_W-1:1]};
		div_start = (state_q == B_DIVX || state_q == B_DIVY || state_q == B_DIVZ) && !pend_q;
		comp      = s_sel[SUM_W-1] ? -$signed(div_q[15:0]) : $signed(div_q[15:0]);
	end

	hvn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Sequencer and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != B_OUT) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (job_valid) state_q <= B_SQUARE;
				end
				B_SQUARE: begin
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					if (root_start) pend_q <= 1'b1;
					if (root_done) begin
						pend_q  <= 1'b0;
						state_q <= (root_val == '0) ? B_OUT : B_DIVX;
					end
				end
				B_DIVX, B_DIVY, B_DIVZ: begin
					if (div_start) pend_q <= 1'b1;
					if (div_done) begin
						pend_q <= 1'b0;
						if (state_q == B_DIVX) state_q <= B_DIVY;
						else if (state_q == B_DIVY) state_q <= B_DIVZ;
						else state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && job_valid) job_q <= job;
		if (state_q == B_SQUARE) begin
			sqx_q <= px;
			sqy_q <= py;
			sqz_q <= pz;
		end
		if (state_q == B_ROOT && root_done) begin
			len_q <= root_val;
			// Faces cancel exactly: point straight up.
			qx_q  <= '0;
			qy_q  <= 16'(1 << NORMAL_FRAC_BITS);
			qz_q  <= '0;
		end
		if (div_done) begin
			if (state_q == B_DIVX) qx_q <= comp;
			if (state_q == B_DIVY) qy_q <= comp;
			if (state_q == B_DIVZ) qz_q <= comp;
		end
		if (state_q == B_OUT && out_free) begin
			vertex_row <= job_q.row;
			vertex_col <= job_q.col;
			normal_x   <= qx_q;
			normal_y   <= qy_q;
			normal_z   <= qz_q;
			last       <= job_q.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/heightmap_vertex_normals_core.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normals_core
// Streams raster heights and emits averaged unit vertex normals.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_ready  | height
//  out     | output    | out_valid / out_ready| vertex_row, vertex_col, normal_*, last
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// For a height that completes a face, the front runs a scale division, a root
// and three divisions on its own serial units, then pushes one to four vertex
// jobs. A height in row 0 or column 0 takes only the scale division. The back
// renormalizes each vertex on a second root and divider, one job at a time.
// A four-entry job queue lets the front run ahead; it stalls when the queue is full.
// Reset clears counters and edge registers; line stores need no clearing.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals_core import hvn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         height,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROW_W-1:0]   vertex_row,
	output logic [COL_W-1:0]   vertex_col,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	cfg_t cfg_q;
	job_t fq_job, qb_job;
	logic fq_valid, fq_ready, qb_valid, qb_ready;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width   <= GW_W'(256);
			cfg_q.grid_height  <= ROW_W'(256);
			cfg_q.height_scale <= 16'd3072;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GRID_WIDTH:   cfg_q.grid_width   <= cfg_data[GW_W-1:0];
				REG_GRID_HEIGHT:  cfg_q.grid_height  <= cfg_data;
				REG_HEIGHT_SCALE: cfg_q.height_scale <= cfg_data;
				default: ;
			endcase
		end
	end

	hvn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.height    (height),
		.job       (fq_job),
		.job_valid (fq_valid),
		.job_ready (fq_ready)
	);

	hvn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (fq_job),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.pop_data   (qb_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready)
	);

	hvn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (qb_job),
		.job_valid  (qb_valid),
		.job_ready  (qb_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.vertex_row (vertex_row),
		.vertex_col (vertex_col),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z),
		.last       (last)
	);

endmodule

FILE: src/hvn_checker.sv
// ----------------------------------------------------------------------------
// hvn_checker
// Port-level checks for the heightmap vertex normal core.
// ----------------------------------------------------------------------------
module hvn_checker import hvn_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic               last
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its normal.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(normal_x) && $stable(normal_y)
			&& $stable(normal_z) && $stable(last))
		else $error("result changed while stalled");

	// The front is busy right after taking an item.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front took items on consecutive cycles");

	// Every vertex normal points upward.
	a_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !normal_y[15])
		else $error("vertex normal points downward");

endmodule

bind heightmap_vertex_normals_core hvn_checker u_hvn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.normal_x  (normal_x),
	.normal_y  (normal_y),
	.normal_z  (normal_z),
	.last      (last)
);
